// ----- rtl/core/gspc_pkg.sv -----
// gspc_pkg: shared constants, types and arithmetic helpers of the gas sensor ppm converter
// no dependencies; used by gas_sensor_ppm_converter_top
package gspc_pkg;

    localparam int RATIO_W    = 32;
    localparam int PPM_W      = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEAK_THR    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUPPLY      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOAD_RES    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_R0          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LPG_SCALE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LPG_EXP     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOKE_SCALE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOKE_EXP   = 3'd7;

    // register reset values
    localparam logic [11:0] RST_LEAK_THR    = 12'd2048;
    localparam logic [15:0] RST_SUPPLY      = 16'd4095;
    localparam logic [23:0] RST_LOAD_RES    = 24'd1000;
    localparam logic [23:0] RST_R0          = 24'd1000;
    localparam logic [23:0] RST_LPG_SCALE   = 24'd147008;
    localparam logic [15:0] RST_LPG_EXP     = 16'hDC73;
    localparam logic [23:0] RST_SMOKE_SCALE = 24'd925722;
    localparam logic [15:0] RST_SMOKE_EXP   = 16'hD533;

    localparam logic [RATIO_W-1:0] RATIO_MIN = 32'd66;
    localparam logic [RATIO_W-1:0] RATIO_MAX = 32'hFFFF_FFFF;
    localparam logic [PPM_W-1:0]   PPM_MAX   = 24'hFF_FFFF;
    localparam logic [31:0]        EXP_ONE   = 32'h4000_0000;

    localparam int DIV_STEPS      = 32;
    localparam int LOG_STEPS      = 16;
    localparam int EXP_BITS       = 16;
    localparam int SQRT_PER_STAGE = 4;
    localparam int SQRT_STAGES    = 8;
    localparam int EXP_STAGES     = EXP_BITS * SQRT_STAGES;
    localparam int NUM_CURVES     = 2;

    typedef struct packed {
        logic                leak;
        logic                sat;
        logic [RATIO_W-1:0]  ratio;
    } side_t;

    typedef struct packed {
        logic signed [9:0] n;
        logic [15:0]       f;
        logic [33:0]       rem;
        logic [31:0]       q;
        logic [33:0]       xs;
    } exp_lane_t;

    // one digit of the restoring square root: returns {rem, root}
    function automatic logic [65:0] sqrt_step(input logic [33:0] rem, input logic [31:0] q,
                                              input logic [1:0] two);
        logic [35:0] rs;
        logic [35:0] t;
        logic [65:0] res;
        rs = {rem, two};
        t  = {2'b00, q, 2'b01};
        if (rs >= t)
        begin
            res = {34'(rs - t), q[30:0], 1'b1};
        end
        else
        begin
            res = {rs[33:0], q[30:0], 1'b0};
        end
        return res;
    endfunction

endpackage

// ----- rtl/core/gas_sensor_ppm_converter_top.sv -----
// gas_sensor_ppm_converter_top: leak flag, Rs/R0 ratio and power-law ppm for lpg and smoke
// depends on gspc_pkg (constants, types, square root digit step)
// throughput one item per cycle while the output is not stalled
// pipeline: 32 divider stages, 16 log2 squaring stages, 128 exp2 square root stages
// (four root digits per stage), multiplier stages around them
// backpressure stalls the whole pipeline; reset clears valid bits and loads register defaults
module gas_sensor_ppm_converter_top #(
    parameter int ADC_BITS  = 12,
    parameter int MIN_COUNT = 13
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // adc_count, comparator_low
    input  logic [((ADC_BITS+8)/8)*8-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // leak, resistance_ratio, lpg_ppm, smoke_ppm, saturated
    output logic [87:0]                       m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gspc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gspc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int DEN_W = 24 + ADC_BITS;

    typedef struct packed {
        logic             leak;
        logic             sat;
        logic [DEN_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [31:0]      xq;
    } div_t;

    typedef struct packed {
        logic                          leak;
        logic                          sat;
        logic [gspc_pkg::RATIO_W-1:0]  ratio;
        logic [4:0]                    p;
        logic [31:0]                   m;
        logic [15:0]                   frac;
    } log_t;

    // configuration registers
    logic [11:0]        thr_reg;
    logic [15:0]        supply_reg;
    logic [23:0]        rl_reg;
    logic [23:0]        r0_reg;
    logic [23:0]        scale_reg [gspc_pkg::NUM_CURVES];
    logic signed [15:0] bexp_reg  [gspc_pkg::NUM_CURVES];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg      <= gspc_pkg::RST_LEAK_THR;
            supply_reg   <= gspc_pkg::RST_SUPPLY;
            rl_reg       <= gspc_pkg::RST_LOAD_RES;
            r0_reg       <= gspc_pkg::RST_R0;
            scale_reg[0] <= gspc_pkg::RST_LPG_SCALE;
            bexp_reg[0]  <= gspc_pkg::RST_LPG_EXP;
            scale_reg[1] <= gspc_pkg::RST_SMOKE_SCALE;
            bexp_reg[1]  <= gspc_pkg::RST_SMOKE_EXP;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                gspc_pkg::CFG_LEAK_THR:    thr_reg      <= cfg_data[11:0];
                gspc_pkg::CFG_SUPPLY:      supply_reg   <= cfg_data[15:0];
                gspc_pkg::CFG_LOAD_RES:    rl_reg       <= cfg_data;
                gspc_pkg::CFG_R0:          r0_reg       <= cfg_data;
                gspc_pkg::CFG_LPG_SCALE:   scale_reg[0] <= cfg_data;
                gspc_pkg::CFG_LPG_EXP:     bexp_reg[0]  <= cfg_data[15:0];
                gspc_pkg::CFG_SMOKE_SCALE: scale_reg[1] <= cfg_data;
                gspc_pkg::CFG_SMOKE_EXP:   bexp_reg[1]  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic out_valid_reg;
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    // ---------------- stage 0: clamp, difference, products
    logic [ADC_BITS-1:0] in_count;
    logic                in_cmp;
    logic [ADC_BITS-1:0] c_w;
    logic [15:0]         d_w;
    logic [39:0]         num_w;
    logic [DEN_W-1:0]    den_w;

    assign in_count = s_tdata[ADC_BITS-1:0];
    assign in_cmp   = s_tdata[ADC_BITS];
    assign c_w      = (in_count < ADC_BITS'(MIN_COUNT)) ? ADC_BITS'(MIN_COUNT) : in_count;
    assign d_w      = (supply_reg > 16'(c_w)) ? supply_reg - 16'(c_w) : 16'd0;
    assign num_w    = 40'(rl_reg) * 40'(d_w);
    assign den_w    = DEN_W'(r0_reg) * DEN_W'(c_w);

    logic             s0_valid_reg;
    logic [39:0]      s0_num_reg;
    logic [DEN_W-1:0] s0_den_reg;
    logic             s0_leak_reg;
    logic             s0_r0z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (en)
            s0_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_num_reg  <= num_w;
            s0_den_reg  <= den_w;
            s0_leak_reg <= in_cmp || (16'(in_count) >= 16'(thr_reg));
            s0_r0z_reg  <= (r0_reg == 24'd0);
        end
    end

    // ---------------- divider: one quotient bit per stage
    logic div_valid_reg [gspc_pkg::DIV_STEPS+1];
    div_t div_reg       [gspc_pkg::DIV_STEPS+1];
    div_t div_init;

    always_comb
    begin
        div_init.leak = s0_leak_reg;
        // quotient would not fit 32 bits
        div_init.sat  = s0_r0z_reg || (DEN_W'(s0_num_reg[39:16]) >= s0_den_reg);
        div_init.rem  = DEN_W'(s0_num_reg[39:16]);
        div_init.den  = s0_den_reg;
        div_init.xq   = {s0_num_reg[15:0], 16'h0000};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_valid_reg[0] <= 1'b0;
        else if (en)
            div_valid_reg[0] <= s0_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            div_reg[0] <= div_init;
    end

    for (genvar i = 0; i < gspc_pkg::DIV_STEPS; i++)
    begin : g_div
        logic [DEN_W:0] rs;
        logic           take;
        div_t           div_next;

        assign rs   = {div_reg[i].rem, div_reg[i].xq[31]};
        assign take = rs >= {1'b0, div_reg[i].den};

        always_comb
        begin
            div_next     = div_reg[i];
            div_next.rem = take ? DEN_W'(rs - {1'b0, div_reg[i].den}) : rs[DEN_W-1:0];
            div_next.xq  = {div_reg[i].xq[30:0], take};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                div_valid_reg[i+1] <= 1'b0;
            else if (en)
                div_valid_reg[i+1] <= div_valid_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                div_reg[i+1] <= div_next;
        end
    end

    // ---------------- ratio saturation and clamp
    logic                 rt_valid_reg;
    gspc_pkg::side_t      rt_reg;
    logic [31:0]          ratio_raw;
    div_t                 div_last;

    assign div_last  = div_reg[gspc_pkg::DIV_STEPS];
    assign ratio_raw = div_last.sat ? gspc_pkg::RATIO_MAX : div_last.xq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rt_valid_reg <= 1'b0;
        else if (en)
            rt_valid_reg <= div_valid_reg[gspc_pkg::DIV_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rt_reg.leak  <= div_last.leak;
            rt_reg.sat   <= div_last.sat;
            rt_reg.ratio <= (ratio_raw < gspc_pkg::RATIO_MIN) ? gspc_pkg::RATIO_MIN : ratio_raw;
        end
    end

    // ---------------- log2: normalize, then one squaring per stage
    logic [4:0] top_w;

    always_comb
    begin
        top_w = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (rt_reg.ratio[i])
                top_w = 5'(i);
        end
    end

    logic lg_valid_reg [gspc_pkg::LOG_STEPS+1];
    log_t lg_reg       [gspc_pkg::LOG_STEPS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lg_valid_reg[0] <= 1'b0;
        else if (en)
            lg_valid_reg[0] <= rt_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lg_reg[0].leak  <= rt_reg.leak;
            lg_reg[0].sat   <= rt_reg.sat;
            lg_reg[0].ratio <= rt_reg.ratio;
            lg_reg[0].p     <= top_w;
            lg_reg[0].m     <= rt_reg.ratio << (5'd31 - top_w);
            lg_reg[0].frac  <= 16'd0;
        end
    end

    for (genvar j = 0; j < gspc_pkg::LOG_STEPS; j++)
    begin : g_log
        logic [63:0] sq;
        logic [32:0] mm;
        log_t        lg_next;

        assign sq = 64'(lg_reg[j].m) * 64'(lg_reg[j].m);
        assign mm = sq[63:31];

        always_comb
        begin
            lg_next      = lg_reg[j];
            lg_next.m    = mm[32] ? mm[32:1] : mm[31:0];
            lg_next.frac = {lg_reg[j].frac[14:0], mm[32]};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                lg_valid_reg[j+1] <= 1'b0;
            else if (en)
                lg_valid_reg[j+1] <= lg_valid_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                lg_reg[j+1] <= lg_next;
        end
    end

    // ---------------- exponent times log
    log_t               lg_last;
    logic signed [5:0]  pe_w;
    logic signed [21:0] lval_w;

    assign lg_last = lg_reg[gspc_pkg::LOG_STEPS];
    assign pe_w    = $signed({1'b0, lg_last.p}) - 6'sd16;
    assign lval_w  = $signed({pe_w, lg_last.frac});

    logic               bp_valid_reg;
    gspc_pkg::side_t    bp_side_reg;
    logic signed [37:0] bp_prod_reg [gspc_pkg::NUM_CURVES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bp_valid_reg <= 1'b0;
        else if (en)
            bp_valid_reg <= lg_valid_reg[gspc_pkg::LOG_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bp_side_reg.leak  <= lg_last.leak;
            bp_side_reg.sat   <= lg_last.sat;
            bp_side_reg.ratio <= lg_last.ratio;
            for (int k = 0; k < gspc_pkg::NUM_CURVES; k++)
                bp_prod_reg[k] <= 38'(bexp_reg[k] * lval_w);
        end
    end

    // ---------------- exp2: 16 square roots, four root digits per stage
    logic                ex_valid_reg [gspc_pkg::EXP_STAGES];
    gspc_pkg::side_t     ex_side_reg  [gspc_pkg::EXP_STAGES];
    gspc_pkg::exp_lane_t ex_reg       [gspc_pkg::EXP_STAGES][gspc_pkg::NUM_CURVES];

    for (genvar e = 0; e < gspc_pkg::EXP_STAGES; e++)
    begin : g_exp
        logic            vin;
        gspc_pkg::side_t side_in;

        if (e == 0)
        begin : g_first
            assign vin     = bp_valid_reg;
            assign side_in = bp_side_reg;
        end
        else
        begin : g_rest
            assign vin     = ex_valid_reg[e-1];
            assign side_in = ex_side_reg[e-1];
        end

        for (genvar k = 0; k < gspc_pkg::NUM_CURVES; k++)
        begin : g_lane
            gspc_pkg::exp_lane_t lin;
            gspc_pkg::exp_lane_t lnext;

            if (e == 0)
            begin : g_seed
                always_comb
                begin
                    lin     = '0;
                    lin.n   = bp_prod_reg[k][37:28];
                    lin.f   = bp_prod_reg[k][27:12];
                    lin.q   = gspc_pkg::EXP_ONE;
                end
            end
            else
            begin : g_pass
                assign lin = ex_reg[e-1][k];
            end

            always_comb
            begin
                logic [31:0] rr;
                logic [65:0] st;
                rr    = '0;
                lnext = lin;
                // start of a new root: take the previous root, doubled when the f bit is set
                if (e % gspc_pkg::SQRT_STAGES == 0)
                begin
                    rr = lin.f[e / gspc_pkg::SQRT_STAGES] ? {lin.q[30:0], 1'b0} : lin.q;
                    lnext.xs  = {2'b00, rr};
                    lnext.rem = '0;
                    lnext.q   = '0;
                end
                for (int s = 0; s < gspc_pkg::SQRT_PER_STAGE; s++)
                begin
                    st        = gspc_pkg::sqrt_step(lnext.rem, lnext.q, lnext.xs[33:32]);
                    lnext.rem = st[65:32];
                    lnext.q   = st[31:0];
                    lnext.xs  = {lnext.xs[31:0], 2'b00};
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                    ex_reg[e][k] <= lnext;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ex_valid_reg[e] <= 1'b0;
            else if (en)
                ex_valid_reg[e] <= vin;
        end

        always_ff @(posedge clk)
        begin
            if (en)
                ex_side_reg[e] <= side_in;
        end
    end

    // ---------------- scale product
    logic              mp_valid_reg;
    gspc_pkg::side_t   mp_side_reg;
    logic [55:0]       mp_prod_reg [gspc_pkg::NUM_CURVES];
    logic signed [9:0] mp_n_reg    [gspc_pkg::NUM_CURVES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mp_valid_reg <= 1'b0;
        else if (en)
            mp_valid_reg <= ex_valid_reg[gspc_pkg::EXP_STAGES-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mp_side_reg <= ex_side_reg[gspc_pkg::EXP_STAGES-1];
            for (int k = 0; k < gspc_pkg::NUM_CURVES; k++)
            begin
                mp_prod_reg[k] <= 56'(scale_reg[k]) * 56'(ex_reg[gspc_pkg::EXP_STAGES-1][k].q);
                mp_n_reg[k]    <= ex_reg[gspc_pkg::EXP_STAGES-1][k].n;
            end
        end
    end

    // ---------------- final shift and saturation
    logic [gspc_pkg::PPM_W-1:0] ppm_w [gspc_pkg::NUM_CURVES];
    logic [gspc_pkg::NUM_CURVES-1:0] psat_w;

    always_comb
    begin
        logic signed [10:0] sh;
        logic [55:0]        v;
        for (int k = 0; k < gspc_pkg::NUM_CURVES; k++)
        begin
            sh        = 11'sd38 - 11'(mp_n_reg[k]);
            v         = mp_prod_reg[k] >> sh[5:0];
            ppm_w[k]  = '0;
            psat_w[k] = 1'b0;
            if (mp_prod_reg[k] == 56'd0)
            begin
                ppm_w[k] = '0;
            end
            else if (sh <= 11'sd0)
            begin
                ppm_w[k]  = gspc_pkg::PPM_MAX;
                psat_w[k] = 1'b1;
            end
            else if (sh >= 11'sd56)
            begin
                ppm_w[k] = '0;
            end
            else if (v > 56'(gspc_pkg::PPM_MAX))
            begin
                ppm_w[k]  = gspc_pkg::PPM_MAX;
                psat_w[k] = 1'b1;
            end
            else
            begin
                ppm_w[k] = v[gspc_pkg::PPM_W-1:0];
            end
        end
    end

    logic [87:0] out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= mp_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data_reg <= {6'd0, mp_side_reg.sat || (|psat_w), ppm_w[1], ppm_w[0],
                             mp_side_reg.ratio, mp_side_reg.leak};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ---------------- checks
    a_ratio_floor: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[32:1] >= gspc_pkg::RATIO_MIN))
        else $error("ratio below floor");

    a_sat_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[81]) |-> (m_tdata[32:1] == gspc_pkg::RATIO_MAX ||
            m_tdata[56:33] == gspc_pkg::PPM_MAX || m_tdata[80:57] == gspc_pkg::PPM_MAX))
        else $error("saturated flag without a saturated field");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> s0_valid_reg)
        else $error("accepted item missing from first stage");

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(ex_valid_reg[0]) && $stable(div_valid_reg[0]) && $stable(mp_valid_reg)))
        else $error("pipeline moved during stall");

endmodule

// ----- bench/tb_gas_sensor_ppm_converter_top.sv -----
// tb_gas_sensor_ppm_converter_top: self-checking bench for the gas sensor ppm converter
// depends on gspc_pkg and gas_sensor_ppm_converter_top; predicts each result in the bench
// and checks it field by field against the stream output
`timescale 1ns / 100ps

module tb_gas_sensor_ppm_converter_top;

    localparam int  ADC_BITS   = 12;
    localparam int  MIN_COUNT  = 13;
    localparam int  DRAIN_WAIT = 400;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic              leak;
        logic [31:0]       ratio;
        logic [23:0]       lpg;
        logic [23:0]       smoke;
        logic              sat;
    } reading_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [gspc_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [gspc_pkg::CFG_DATA_W-1:0] cfg_data;

    // sensor settings as the block should hold them
    logic [11:0] thr_q;
    logic [15:0] supply_q;
    logic [23:0] rl_q;
    logic [23:0] r0_q;
    logic [23:0] lpg_a_q;
    logic [15:0] lpg_b_q;
    logic [23:0] smoke_a_q;
    logic [15:0] smoke_b_q;

    reading_t    pending_readings[$];
    int          error_count = 0;
    longint      cycle_count = 0;
    bit          idle_on;

    gas_sensor_ppm_converter_top #(
        .ADC_BITS (ADC_BITS),
        .MIN_COUNT(MIN_COUNT)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // log2 of a nonzero Q16.16 value as signed Q.16
    function automatic longint ratio_log2(input logic [31:0] x);
        int          p;
        logic [63:0] m;
        logic [15:0] frac;
        p    = 31;
        frac = 0;
        while (p > 0 && x[p] == 1'b0)
            p--;
        m = 64'(x) << (31 - p);
        for (int i = 0; i < 16; i++)
        begin
            m    = (m * m) >> 31;
            frac = frac << 1;
            if (m >= (64'd1 << 32))
            begin
                frac[0] = 1'b1;
                m       = m >> 1;
            end
        end
        return longint'(p - 16) * 65536 + longint'(frac);
    endfunction

    // A * ratio^B through exp2 of B*log2(ratio); sets sat on overflow
    function automatic logic [23:0] curve_ppm(input logic [23:0] scale,
                                              input logic [15:0] expo,
                                              input longint lg, inout logic sat);
        longint      y;
        longint      n;
        logic [15:0] f;
        logic [63:0] r;
        logic [63:0] prod;
        longint      shift;
        y = (longint'($signed(expo)) * lg) >>> 12;
        n = y >>> 16;
        f = y[15:0];
        r = 64'd1 << 30;
        for (int k = 0; k < 16; k++)
        begin
            if (f[k])
                r = r << 1;
            r = int_sqrt(r << 30);
        end
        prod = 64'(scale) * r;
        if (prod == 0)
            return 24'd0;
        shift = 38 - n;
        if (shift <= 0)
        begin
            sat = 1'b1;
            return gspc_pkg::PPM_MAX;
        end
        if (shift >= 64)
            return 24'd0;
        prod = prod >> shift;
        if (prod > 64'(gspc_pkg::PPM_MAX))
        begin
            sat = 1'b1;
            return gspc_pkg::PPM_MAX;
        end
        return prod[23:0];
    endfunction

    function automatic reading_t sensor_reading(input logic [11:0] count, input logic cmp);
        reading_t    rd;
        logic [31:0] c;
        logic [31:0] d;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] q;
        longint      lg;
        logic        sat;
        c   = (count < MIN_COUNT) ? MIN_COUNT : 32'(count);
        d   = (32'(supply_q) > c) ? 32'(supply_q) - c : 32'd0;
        sat = 1'b0;
        rd.leak = cmp || (count >= thr_q);
        if (r0_q == 0)
        begin
            rd.ratio = gspc_pkg::RATIO_MAX;
            sat      = 1'b1;
        end
        else
        begin
            num = (64'(rl_q) * 64'(d)) << 16;
            den = 64'(r0_q) * 64'(c);
            q   = num / den;
            if (q > 64'hFFFF_FFFF)
            begin
                rd.ratio = gspc_pkg::RATIO_MAX;
                sat      = 1'b1;
            end
            else
            begin
                rd.ratio = q[31:0];
            end
        end
        if (rd.ratio < gspc_pkg::RATIO_MIN)
            rd.ratio = gspc_pkg::RATIO_MIN;
        lg       = ratio_log2(rd.ratio);
        rd.lpg   = curve_ppm(lpg_a_q, lpg_b_q, lg, sat);
        rd.smoke = curve_ppm(smoke_a_q, smoke_b_q, lg, sat);
        rd.sat   = sat;
        return rd;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    endtask

    // result checker
    always @(posedge clk)
    begin
        reading_t got;
        reading_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.leak  = m_tdata[0];
            got.ratio = m_tdata[32:1];
            got.lpg   = m_tdata[56:33];
            got.smoke = m_tdata[80:57];
            got.sat   = m_tdata[81];
            if (pending_readings.size() == 0)
            begin
                report_mismatch("unexpected item", 32'd0, 32'd0);
            end
            else
            begin
                want = pending_readings.pop_front();
                if (got.leak != want.leak)
                    report_mismatch("leak", 32'(got.leak), 32'(want.leak));
                if (got.ratio != want.ratio)
                    report_mismatch("resistance_ratio", got.ratio, want.ratio);
                if (got.lpg != want.lpg)
                    report_mismatch("lpg_ppm", 32'(got.lpg), 32'(want.lpg));
                if (got.smoke != want.smoke)
                    report_mismatch("smoke_ppm", 32'(got.smoke), 32'(want.smoke));
                if (got.sat != want.sat)
                    report_mismatch("saturated", 32'(got.sat), 32'(want.sat));
            end
        end
    end

    // output stalls in bursts
    initial
    begin
        m_tready = 1'b1;
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_sample(input logic [11:0] count, input logic cmp);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, cmp, count};
        do
            @(posedge clk);
        while (!s_tready);
        pending_readings.push_back(sensor_reading(count, cmp));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        wait (pending_readings.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // writes all eight registers, block idle
    task automatic load_settings(input logic [11:0] thr, input logic [15:0] supply,
                                 input logic [23:0] rl, input logic [23:0] r0,
                                 input logic [23:0] la, input logic [15:0] lb,
                                 input logic [23:0] sa, input logic [15:0] sb);
        logic [23:0] vals[8];
        logic [gspc_pkg::CFG_IDX_W-1:0] idx[8];
        vals = '{24'(thr), 24'(supply), rl, r0, la, 24'(lb), sa, 24'(sb)};
        idx  = '{gspc_pkg::CFG_LEAK_THR, gspc_pkg::CFG_SUPPLY, gspc_pkg::CFG_LOAD_RES,
                 gspc_pkg::CFG_R0, gspc_pkg::CFG_LPG_SCALE, gspc_pkg::CFG_LPG_EXP,
                 gspc_pkg::CFG_SMOKE_SCALE, gspc_pkg::CFG_SMOKE_EXP};
        for (int i = 0; i < 8; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        thr_q = thr; supply_q = supply; rl_q = rl; r0_q = r0;
        lpg_a_q = la; lpg_b_q = lb; smoke_a_q = sa; smoke_b_q = sb;
    endtask

    function automatic logic [23:0] pick24(input logic [23:0] lo);
        case ($urandom_range(0, 5))
            0: return lo;
            1: return gspc_pkg::PPM_MAX;
            2: return 24'($urandom_range(1, 2000));
            default: return 24'($urandom_range(1, 200000));
        endcase
    endfunction

    function automatic logic [11:0] pick_count();
        case ($urandom_range(0, 3))
            0: return 12'($urandom_range(0, 20));
            1: return 12'(thr_q + $urandom_range(0, 4) - 2);
            default: return 12'($urandom);
        endcase
    endfunction

    task automatic test_reset_settings();
        logic [11:0] counts[12];
        counts = '{12'd0, 12'd1, 12'd12, 12'd13, 12'd14, 12'd100, 12'd2047,
                   12'd2048, 12'd2049, 12'd3000, 12'd4094, 12'd4095};
        foreach (counts[i])
        begin
            send_sample(counts[i], 1'b0);
            send_sample(counts[i], 1'b1);
        end
        drain_results();
    endtask

    task automatic test_corner_settings();
        // supply below count and zero scales
        load_settings(12'd0, 16'd0, 24'd1, 24'd1, 24'd0, 16'h8000, 24'd0, 16'h7FFF);
        send_sample(12'd0, 1'b0);
        send_sample(12'd4095, 1'b0);
        drain_results();
        // clean air resistance zero saturates the ratio
        load_settings(12'd4095, 16'hFFFF, gspc_pkg::PPM_MAX, 24'd0, gspc_pkg::PPM_MAX,
                      16'h7FFF, gspc_pkg::PPM_MAX, 16'h8000);
        send_sample(12'd13, 1'b0);
        send_sample(12'd4095, 1'b1);
        drain_results();
        // huge ratio with extreme exponents: overflow and vanishing results
        load_settings(12'd4095, 16'hFFFF, gspc_pkg::PPM_MAX, 24'd1, gspc_pkg::PPM_MAX,
                      16'h7FFF, gspc_pkg::PPM_MAX, 16'h8000);
        send_sample(12'd0, 1'b0);
        send_sample(12'd2000, 1'b0);
        send_sample(12'd4094, 1'b0);
        drain_results();
        // tiny ratio
        load_settings(12'd1, 16'd4095, 24'd1, gspc_pkg::PPM_MAX, gspc_pkg::PPM_MAX,
                      16'h8000, 24'd1, 16'h7FFF);
        send_sample(12'd13, 1'b0);
        send_sample(12'd4000, 1'b1);
        drain_results();
    endtask

    task automatic test_random_phases();
        logic [15:0] supply;
        for (int ph = 0; ph < 6; ph++)
        begin
            idle_on = (ph < 5);
            supply  = ($urandom_range(0, 2) == 0) ? 16'($urandom) :
                      16'($urandom_range(3500, 4400));
            load_settings(12'($urandom), supply, pick24(24'd1),
                          ($urandom_range(0, 15) == 0) ? 24'd0 : pick24(24'd1),
                          pick24(24'd0),
                          ($urandom_range(0, 1) == 0) ? 16'($urandom) :
                          16'($signed(16'($urandom_range(0, 16000))) - 16'sd12000),
                          pick24(24'd0), 16'($urandom));
            for (int i = 0; i < 222; i++)
                send_sample(pick_count(), 1'($urandom));
            drain_results();
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = gspc_pkg::CFG_LEAK_THR;
        cfg_data    = '0;
        idle_on     = 1'b1;
        thr_q = gspc_pkg::RST_LEAK_THR; supply_q = gspc_pkg::RST_SUPPLY;
        rl_q = gspc_pkg::RST_LOAD_RES; r0_q = gspc_pkg::RST_R0;
        lpg_a_q = gspc_pkg::RST_LPG_SCALE; lpg_b_q = gspc_pkg::RST_LPG_EXP;
        smoke_a_q = gspc_pkg::RST_SMOKE_SCALE; smoke_b_q = gspc_pkg::RST_SMOKE_EXP;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_settings();
        test_corner_settings();
        test_random_phases();

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
